// ===== rtl/longest_common_substring_length_macros.svh =====
// Assertion macros for the files that carry checks.
`ifndef LONGEST_COMMON_SUBSTRING_LENGTH_MACROS_SVH
`define LONGEST_COMMON_SUBSTRING_LENGTH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lcsl_pkg.sv =====
package lcsl_pkg;

	// Field widths of the item and result words.
	localparam int KIND_W = 2;
	localparam int CH_W   = 8;
	localparam int LEN_W  = 7;

	// Largest length the result field can show.
	localparam int LEN_MAX = 127;

	// Default capacity of the first-string store.
	localparam int MAX_LEN_DEF = 64;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_first;
		logic start_second;
		logic emit;
		logic rd_en;
		logic wr_en;
	} cmd_t;

endpackage

// ===== rtl/lcsl_ifs.sv =====
// Input channel: one word per string byte or end marker.
interface lcsl_item_if;
	logic                        valid;
	logic                        ready;
	logic [lcsl_pkg::KIND_W-1:0] kind;
	logic [lcsl_pkg::CH_W-1:0]   ch;

	modport source (output valid, output kind, output ch, input ready);
	modport sink (input valid, input kind, input ch, output ready);
endinterface

// Output channel: one word per string pair.
interface lcsl_result_if;
	logic                       valid;
	logic                       ready;
	logic [lcsl_pkg::LEN_W-1:0] length;
	logic                       truncated;
	logic                       order_error;

	modport source (output valid, output length, output truncated, output order_error,
		input ready);
	modport sink (input valid, input length, input truncated, input order_error,
		output ready);
endinterface

// ===== rtl/longest_common_substring_length.sv =====
// First-string and end words need no sweep; the result word is offered the cycle after
// the end word is accepted and is held until taken.
// A second-string word starts a sweep over the n stored bytes (no sweep if none): the row of suffix
// lengths is swept one cell per cycle through the read port and the write port of the row memory.
// Asynchronous active-low reset clears the control state and flags; the memories are not
// cleared, and the suffix row is treated as zero until the first sweep has rewritten it.
`include "longest_common_substring_length_macros.svh"

module longest_common_substring_length #(
	parameter int MAX_LEN = lcsl_pkg::MAX_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lcsl_item_if.sink     item,
	lcsl_result_if.source result
);

	import lcsl_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	cmd_t          cmd;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] count;

	// Controller: handshakes and sweep sequencing.
	lcsl_ctrl #(
		.MAX_LEN(MAX_LEN)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_kind  (item.kind),
		.in_ready (item.ready),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.count    (count),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	// Datapath: string store, suffix row, maximum and flags.
	lcsl_dp #(
		.MAX_LEN(MAX_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_ch      (item.ch),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.count      (count),
		.length     (result.length),
		.truncated  (result.truncated),
		.order_error(result.order_error)
	);

	// No word is taken while the row is being swept.
	`LCSL_ASSERT_NOW(a_no_accept_in_sweep, clk, arst_n, cmd.rd_en || cmd.wr_en, !item.ready, "word accepted during a sweep")

	// A sweep only reads cells that hold a stored byte.
	`LCSL_ASSERT_NOW(a_read_in_range, clk, arst_n, cmd.rd_en, CW'(rd_addr) < count, "sweep read beyond the stored bytes")

	// An accepted end word always yields a result word in the next cycle.
	`LCSL_ASSERT_NEXT(a_end_gives_result, clk, arst_n, item.valid && item.ready && (item.kind == KIND_END), result.valid, "end word gave no result")

endmodule

// ===== rtl/lcsl_ram.sv =====
module lcsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/lcsl_ctrl.sv =====
module lcsl_ctrl #(
	parameter int MAX_LEN = lcsl_pkg::MAX_LEN_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	input  logic [lcsl_pkg::KIND_W-1:0]                 in_kind,
	output logic                                        in_ready,
	input  logic                                        out_ready,
	output logic                                        out_valid,
	input  logic [$clog2(MAX_LEN+1)-1:0]                count,
	output lcsl_pkg::cmd_t                              cmd,
	output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_addr,
	output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr
);

	import lcsl_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]    state_q;
	logic [1:0]    state_d;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] addr_s1;
	logic          valid_s1;
	logic          out_valid_q;
	logic          accept;
	logic          last_cell;

	// A word is taken only between sweeps and when the result slot can move on.
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode the kind of the accepted word; the unused kind does nothing.
	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (in_kind)
				KIND_FIRST:  cmd.load_first   = 1'b1;
				KIND_SECOND: cmd.start_second = 1'b1;
				KIND_END:    cmd.emit         = 1'b1;
				default:     cmd.load_first   = 1'b0;
			endcase
		end
		cmd.rd_en = (state_q == ST_SWEEP);
		cmd.wr_en = valid_s1;
	end

	assign rd_addr   = idx_q;
	assign wr_addr   = addr_s1;
	assign last_cell = ((CW'(idx_q) + CW'(1)) == count);

	// Sweep sequencing: one cell read per cycle, then a drain state to finish the last write.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start_second && (count != '0)) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (last_cell) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_SWEEP);
			if (state_q == ST_SWEEP) begin
				idx_q <= idx_q + AW'(1);
			end else begin
				idx_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Address of the cell whose read data arrive in the next cycle.
	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
	end

endmodule

// ===== rtl/lcsl_dp.sv =====
module lcsl_dp #(
	parameter int MAX_LEN = lcsl_pkg::MAX_LEN_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  lcsl_pkg::cmd_t                              cmd,
	input  logic [lcsl_pkg::CH_W-1:0]                   in_ch,
	input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_addr,
	input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
	output logic [$clog2(MAX_LEN+1)-1:0]                count,
	output logic [lcsl_pkg::LEN_W-1:0]                  length,
	output logic                                        truncated,
	output logic                                        order_error
);

	import lcsl_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int WW = (CW > LEN_W) ? CW : LEN_W;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   best_q;
	logic            started_q;
	logic            trunc_q;
	logic            order_q;
	logic            use_old_q;
	logic [CW-1:0]   prev_q;
	logic [CH_W-1:0] ch_q;
	logic [LEN_W-1:0] len_q;
	logic            trunc_out_q;
	logic            order_out_q;

	logic            store_we;
	logic [CH_W-1:0] first_rd;
	logic [CW-1:0]   row_rd;
	logic [CW-1:0]   old_v;
	logic [CW-1:0]   new_v;
	logic [WW-1:0]   best_w;
	logic [LEN_W-1:0] len_sat;

	// A first-string byte is stored only before the second string and while room is left.
	assign store_we = cmd.load_first && !started_q && (count_q != CW'(MAX_LEN));

	lcsl_ram #(
		.WIDTH(CH_W),
		.DEPTH(MAX_LEN)
	) u_first_ram (
		.clk  (clk),
		.we   (store_we),
		.waddr(count_q[AW-1:0]),
		.wdata(in_ch),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(first_rd)
	);

	lcsl_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_LEN)
	) u_row_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_addr),
		.wdata(new_v),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(row_rd)
	);

	// The row holds stale data until the first second-string byte has rewritten it.
	assign old_v = use_old_q ? row_rd : '0;
	assign new_v = (first_rd == ch_q) ? (prev_q + CW'(1)) : '0;

	// Saturate the running maximum to the width of the result field.
	assign best_w  = WW'(best_q);
	assign len_sat = (best_w > WW'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(best_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			best_q    <= '0;
			started_q <= 1'b0;
			trunc_q   <= 1'b0;
			order_q   <= 1'b0;
			use_old_q <= 1'b0;
			prev_q    <= '0;
		end else begin
			if (cmd.load_first) begin
				if (started_q) begin
					order_q <= 1'b1;
				end else if (count_q == CW'(MAX_LEN)) begin
					trunc_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.start_second) begin
				use_old_q <= started_q;
				started_q <= 1'b1;
				prev_q    <= '0;
			end
			// Cell update: carry the old left neighbour along and track the maximum.
			if (cmd.wr_en) begin
				prev_q <= old_v;
				if (new_v > best_q) begin
					best_q <= new_v;
				end
			end
			if (cmd.emit) begin
				count_q   <= '0;
				best_q    <= '0;
				started_q <= 1'b0;
				trunc_q   <= 1'b0;
				order_q   <= 1'b0;
				use_old_q <= 1'b0;
			end
		end
	end

	// Second-string byte and result word payload.
	always_ff @(posedge clk) begin
		if (cmd.start_second) begin
			ch_q <= in_ch;
		end
		if (cmd.emit) begin
			len_q       <= len_sat;
			trunc_out_q <= trunc_q;
			order_out_q <= order_q;
		end
	end

	assign count       = count_q;
	assign length      = len_q;
	assign truncated   = trunc_out_q;
	assign order_error = order_out_q;

endmodule

// ===== bench/tb_longest_common_substring_length.sv =====
import lcsl_pkg::*;

// Expected result word for one string pair.
typedef struct packed {
	logic [LEN_W-1:0] length;
	logic             truncated;
	logic             order_error;
} lcs_result_t;

// Tracks the common-substring state of the block and checks its result words.
class lcs_scoreboard;
	logic [CH_W-1:0] stored[MAX_LEN_DEF];
	int              suffix_len[MAX_LEN_DEF];
	int              stored_count;
	int              best_len;
	bit              second_seen;
	bit              trunc_seen;
	bit              order_seen;
	lcs_result_t     pending_results[$];
	int              mismatches;

	function new();
		mismatches = 0;
		clear_pair();
	endfunction

	function void clear_pair();
		foreach (suffix_len[i])
			suffix_len[i] = 0;
		stored_count = 0;
		best_len     = 0;
		second_seen  = 0;
		trunc_seen   = 0;
		order_seen   = 0;
	endfunction

	// Update the predicted state with one accepted input word.
	function void note_word(logic [KIND_W-1:0] kind, logic [CH_W-1:0] ch);
		lcs_result_t res;
		int          sfx;
		case (kind)
			KIND_FIRST: begin
				if (second_seen)
					order_seen = 1;
				else if (stored_count >= MAX_LEN_DEF)
					trunc_seen = 1;
				else begin
					stored[stored_count] = ch;
					stored_count++;
				end
			end
			KIND_SECOND: begin
				// Walk downwards so each entry still sees its neighbour's old value.
				for (int k = stored_count - 1; k >= 0; k--) begin
					sfx = 0;
					if (stored[k] == ch) begin
						sfx = (k == 0) ? 1 : suffix_len[k-1] + 1;
						if (sfx > best_len)
							best_len = sfx;
					end
					suffix_len[k] = sfx;
				end
				second_seen = 1;
			end
			KIND_END: begin
				res.length      = (best_len > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(best_len);
				res.truncated   = trunc_seen;
				res.order_error = order_seen;
				pending_results = {pending_results, res};
				clear_pair();
			end
			default: begin
				// The unused kind leaves everything as it was.
			end
		endcase
	endfunction

	// Compare one accepted result word with the oldest expectation.
	function void check_result(logic [LEN_W-1:0] length, logic truncated, logic order_error);
		lcs_result_t want;
		if (pending_results.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: unexpected result word: length %0d truncated %0b order %0b",
					$time, length, truncated, order_error);
			mismatches++;
			return;
		end
		want = pending_results.pop_front();
		if (length !== want.length || truncated !== want.truncated ||
				order_error !== want.order_error) begin
			if (mismatches < 10)
				$display("%0t: result mismatch: expected length %0d truncated %0b order %0b, got length %0d truncated %0b order %0b",
					$time, want.length, want.truncated, want.order_error,
					length, truncated, order_error);
			mismatches++;
		end
	endfunction
endclass

module tb_longest_common_substring_length;

	// The block ignores this selector value.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int WORD_TARGET = 1250;
	localparam int CALM_FROM   = 1050;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lcsl_item_if   items_ch();
	lcsl_result_if results_ch();

	lcs_scoreboard sb = new();

	int words_sent = 0;
	bit calm       = 0;
	int gap_pct    = 0;
	int stall_pct  = 0;

	longest_common_substring_length i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (items_ch),
		.result (results_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up if the run hangs.
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Check every result word taken from the block.
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready)
			sb.check_result(results_ch.length, results_ch.truncated, results_ch.order_error);
	end

	// Result sink: ready drops in random bursts while stalls are enabled.
	initial begin
		int hold;
		hold = 0;
		results_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold == 0 && !calm && $urandom_range(0, 99) < stall_pct)
				hold = $urandom_range(1, 17);
			if (hold != 0) begin
				results_ch.ready <= 1'b0;
				hold--;
			end else begin
				results_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one word from a falling edge and hold it until the block takes it.
	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch);
		int gap;
		if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 17);
			items_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.kind  <= kind;
		items_ch.ch    <= ch;
		@(posedge clk);
		while (!items_ch.ready)
			@(posedge clk);
		sb.note_word(kind, ch);
		if (kind != KIND_UNUSED)
			words_sent++;
		@(negedge clk);
	endtask

	// A byte from a narrow band starting at base, or from the full range.
	function automatic logic [CH_W-1:0] pick_byte(bit narrow, logic [CH_W-1:0] base);
		if (narrow)
			return base + CH_W'($urandom_range(0, 2));
		return CH_W'($urandom_range(0, 255));
	endfunction

	// Send a whole pair, with optional stray first-string bytes and unused-kind noise.
	task automatic send_pair(input logic [CH_W-1:0] first_q[$], input logic [CH_W-1:0] second_q[$],
			input int order_pct, input int noise_pct);
		foreach (first_q[i]) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_word(KIND_UNUSED, CH_W'($urandom_range(0, 255)));
			send_word(KIND_FIRST, first_q[i]);
		end
		foreach (second_q[i]) begin
			send_word(KIND_SECOND, second_q[i]);
			if ($urandom_range(0, 99) < order_pct)
				send_word(KIND_FIRST, CH_W'($urandom_range(0, 255)));
			if ($urandom_range(0, 99) < noise_pct)
				send_word(KIND_UNUSED, CH_W'($urandom_range(0, 255)));
		end
		send_word(KIND_END, CH_W'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [CH_W-1:0] fs[$];
		logic [CH_W-1:0] ss[$];
		logic [CH_W-1:0] base;
		int              pair_no;
		int              mode;
		int              flen;
		int              slen;
		int              s;
		int              run;
		int              order_pct;
		bit              narrow;

		items_ch.valid = 1'b0;
		items_ch.kind  = KIND_FIRST;
		items_ch.ch    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words: empty strings, byte extremes, the unused kind and a late first byte.
		send_word(KIND_END, 8'h00);
		send_word(KIND_FIRST, 8'h41);
		send_word(KIND_END, 8'hFF);
		send_word(KIND_SECOND, 8'h41);
		send_word(KIND_END, 8'h00);
		send_word(KIND_FIRST, 8'h00);
		send_word(KIND_FIRST, 8'hFF);
		send_word(KIND_SECOND, 8'hFF);
		send_word(KIND_SECOND, 8'h00);
		send_word(KIND_SECOND, 8'hFF);
		send_word(KIND_END, 8'h00);
		send_word(KIND_UNUSED, 8'h5A);
		send_word(KIND_FIRST, 8'h5A);
		send_word(KIND_UNUSED, 8'hA5);
		send_word(KIND_SECOND, 8'h5A);
		send_word(KIND_END, 8'h00);
		send_word(KIND_FIRST, 8'h11);
		send_word(KIND_SECOND, 8'h11);
		send_word(KIND_FIRST, 8'h22);
		send_word(KIND_SECOND, 8'h22);
		send_word(KIND_END, 8'h00);
		send_word(KIND_FIRST, 8'h33);
		send_word(KIND_FIRST, 8'h33);
		send_word(KIND_SECOND, 8'h33);
		send_word(KIND_SECOND, 8'h33);
		send_word(KIND_END, 8'h7F);

		// Random pairs; the first few are forced to an overlong string and a full-length match.
		pair_no = 0;
		while (words_sent < WORD_TARGET) begin
			if (words_sent >= CALM_FROM)
				calm = 1;
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 20;
				default: gap_pct = 50;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 20;
				default: stall_pct = 50;
			endcase

			fs.delete();
			ss.delete();
			narrow    = ($urandom_range(0, 9) < 7);
			base      = CH_W'($urandom_range(0, 255));
			order_pct = ($urandom_range(0, 9) == 0) ? 15 : 0;
			mode      = $urandom_range(0, 99);
			if (pair_no == 0 || (pair_no > 2 && mode < 4)) begin
				flen = $urandom_range(MAX_LEN_DEF + 1, MAX_LEN_DEF + 8);
				slen = $urandom_range(1, 12);
			end else if (pair_no == 1) begin
				flen = MAX_LEN_DEF;
				slen = MAX_LEN_DEF;
			end else if (pair_no == 2) begin
				flen      = MAX_LEN_DEF + 2;
				slen      = 4;
				order_pct = 50;
			end else if (mode < 10) begin
				flen = $urandom_range(40, MAX_LEN_DEF);
				slen = $urandom_range(0, 16);
			end else begin
				flen = $urandom_range(0, 12);
				slen = $urandom_range(0, 14);
			end

			for (int i = 0; i < flen; i++)
				fs = {fs, pick_byte(narrow, base)};
			if (pair_no == 1) begin
				ss = fs;
			end else begin
				// Second string: runs copied from the first string mixed with random bytes.
				while (ss.size() < slen) begin
					if (fs.size() != 0 && $urandom_range(0, 1) == 1) begin
						s   = $urandom_range(0, fs.size() - 1);
						run = $urandom_range(1, fs.size() - s);
						for (int j = s; j < s + run && ss.size() < slen; j++)
							ss = {ss, fs[j]};
					end else begin
						ss = {ss, pick_byte(narrow, base)};
					end
				end
			end
			send_pair(fs, ss, order_pct, 3);
			pair_no++;
		end
		items_ch.valid <= 1'b0;

		// Drain the outstanding result words, then let any last sweep finish.
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lcsl_pkg.sv
rtl/lcsl_ifs.sv
rtl/lcsl_ram.sv
rtl/lcsl_ctrl.sv
rtl/lcsl_dp.sv
rtl/longest_common_substring_length.sv
bench/tb_longest_common_substring_length.sv
